>>> src/sirq_pkg.sv
`default_nettype none
package sirq_pkg;

  localparam logic [2:0] CMD_ACQUIRE    = 3'd0;
  localparam logic [2:0] CMD_WAIT       = 3'd1;
  localparam logic [2:0] CMD_RELEASE    = 3'd2;
  localparam logic [2:0] CMD_DOWNSTREAM = 3'd3;
  localparam logic [2:0] CMD_CLEAR      = 3'd4;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] image_id;
  } cmd_t;

  typedef struct packed {
    logic       found;
    logic [7:0] result_index;
    logic [3:0] occupancy;
    logic [3:0] pending_downstream;
    logic       overflow;
  } res_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
  } ctrl_t;

endpackage
`default_nettype wire

>>> src/sirq_control.sv
`default_nettype none
module sirq_control
  import sirq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cmd_valid,
  output logic       cmd_stall,
  output logic       res_valid,
  input  wire logic  res_stall,
  output ctrl_t      ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_stall  = 1'b1;
    res_valid  = 1'b0;
    ctrl.load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          ctrl.load  = 1'b1;
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        res_valid = 1'b1;
        if (!res_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/sirq_datapath.sv
`default_nettype none
module sirq_datapath
  import sirq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8,
  parameter int INDEX_BITS  = 8
)
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire ctrl_t ctrl,
  input  wire cmd_t  cmd,
  output res_t       res
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);

  logic [INDEX_BITS-1:0] mem [QUEUE_DEPTH];
  logic [INDEX_BITS-1:0] rd_data;
  logic [PW-1:0]         head;
  logic [PW-1:0]         head_next;
  logic [CW-1:0]         entry_count;
  logic [CW-1:0]         entry_count_next;
  logic [CW-1:0]         waited_count;
  logic [CW-1:0]         waited_count_next;
  logic [CW-1:0]         released_count;
  logic [CW-1:0]         released_count_next;
  logic                  found;
  logic                  found_next;
  logic                  overflow;
  logic                  overflow_next;

  logic                  rd_en;
  logic [PW-1:0]         rd_addr;
  logic                  wr_en;
  logic [PW-1:0]         wr_addr;
  logic [INDEX_BITS+7:0] idx_wide;
  logic [INDEX_BITS-1:0] wr_data;
  logic [INDEX_BITS+7:0] rd_wide;
  logic [CW+3:0]         occ_wide;
  logic [CW+3:0]         pend_wide;

  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                            input logic [CW-1:0] offset);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(offset);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[PW-1:0];
  endfunction

  assign idx_wide = {{INDEX_BITS{1'b0}}, cmd.image_id};
  assign wr_data  = idx_wide[INDEX_BITS-1:0];

  always_comb begin
    head_next           = head;
    entry_count_next    = entry_count;
    waited_count_next   = waited_count;
    released_count_next = released_count;
    found_next          = 1'b0;
    overflow_next       = 1'b0;
    rd_en               = 1'b0;
    rd_addr             = head;
    wr_en               = 1'b0;
    wr_addr             = slot_of(head, entry_count);
    unique case (cmd.command)
      CMD_ACQUIRE: begin
        if (entry_count >= DEPTH_C) begin
          overflow_next = 1'b1;
        end else begin
          wr_en            = ctrl.load;
          entry_count_next = entry_count + CW'(1);
        end
      end
      CMD_WAIT: begin
        if (waited_count < entry_count) begin
          found_next        = 1'b1;
          rd_en             = ctrl.load;
          rd_addr           = slot_of(head, waited_count);
          waited_count_next = waited_count + CW'(1);
        end
      end
      CMD_RELEASE: begin
        if (released_count < waited_count) begin
          found_next          = 1'b1;
          rd_en               = ctrl.load;
          rd_addr             = slot_of(head, released_count);
          released_count_next = released_count + CW'(1);
        end
      end
      CMD_DOWNSTREAM: begin
        if (released_count != '0) begin
          found_next          = 1'b1;
          rd_en               = ctrl.load;
          rd_addr             = head;
          head_next           = slot_of(head, CW'(1));
          entry_count_next    = entry_count - CW'(1);
          waited_count_next   = waited_count - CW'(1);
          released_count_next = released_count - CW'(1);
        end
      end
      CMD_CLEAR: begin
        head_next           = '0;
        entry_count_next    = '0;
        waited_count_next   = '0;
        released_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head           <= '0;
      entry_count    <= '0;
      waited_count   <= '0;
      released_count <= '0;
      found          <= 1'b0;
      overflow       <= 1'b0;
    end else if (ctrl.load) begin
      head           <= head_next;
      entry_count    <= entry_count_next;
      waited_count   <= waited_count_next;
      released_count <= released_count_next;
      found          <= found_next;
      overflow       <= overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rd_wide   = {8'd0, rd_data};
  assign occ_wide  = {4'd0, entry_count};
  assign pend_wide = {4'd0, released_count};

  always_comb begin
    res.found              = found;
    res.result_index       = found ? rd_wide[7:0] : 8'd0;
    res.occupancy          = occ_wide[3:0];
    res.pending_downstream = pend_wide[3:0];
    res.overflow           = overflow;
  end

endmodule
`default_nettype wire

>>> src/staged_image_release_queue.sv
`default_nettype none
// In-order queue of acquired image indices with three stage marks (acquired,
// waited, app released), kept as counts from the head; a downstream release
// moves the head. Each command transaction yields exactly one result
// transaction. A command is taken, and its result is offered from the
// following cycle and held until taken; a new command is taken only once
// the previous result has gone. This follows from the registered read of
// the index memory and the single result register. An acquire into a full
// queue is dropped and flagged by overflow.
module staged_image_release_queue
  import sirq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8,
  parameter int INDEX_BITS  = 8
)
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res
);

  ctrl_t ctrl;

  sirq_control u_control (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .ctrl      (ctrl)
  );

  sirq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .cmd  (cmd),
    .res  (res)
  );

endmodule
`default_nettype wire

>>> dv/staged_image_release_queue_tb.sv
module staged_image_release_queue_tb;
  import sirq_pkg::*;

  localparam int DEPTH = 8;
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam int RANDOM_ITEMS   = 900;
  localparam int REPORT_LIMIT   = 10;
  localparam int QUIET_LIMIT    = 5000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    cmd_t item;
    logic typed;
    res_t want;
  } step_row_t;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic res_valid;
  logic res_stall;
  res_t res;

  logic [7:0] slot_image [DEPTH];
  logic [2:0] head_slot;
  logic [3:0] held_count;
  logic [3:0] waited_count;
  logic [3:0] released_count;

  res_t      expected_results [$];
  int        mismatches;
  int        quiet_cycles;
  bit        calm;
  bit        squeeze_req;
  step_row_t directed_steps [25];

  staged_image_release_queue uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic res_t advance_queue(input cmd_t item);
    res_t       r;
    logic [2:0] slot;
    r = '0;
    case (item.command)
      CMD_ACQUIRE: begin
        if (held_count >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          slot = head_slot + held_count[2:0];
          slot_image[slot] = item.image_id;
          held_count++;
        end
      end
      CMD_WAIT: begin
        if (waited_count < held_count) begin
          slot = head_slot + waited_count[2:0];
          r.found = 1'b1;
          r.result_index = slot_image[slot];
          waited_count++;
        end
      end
      CMD_RELEASE: begin
        if (released_count < waited_count) begin
          slot = head_slot + released_count[2:0];
          r.found = 1'b1;
          r.result_index = slot_image[slot];
          released_count++;
        end
      end
      CMD_DOWNSTREAM: begin
        if (released_count > 0) begin
          r.found = 1'b1;
          r.result_index = slot_image[head_slot];
          head_slot++;
          held_count--;
          waited_count--;
          released_count--;
        end
      end
      CMD_CLEAR: begin
        head_slot = '0;
        held_count = '0;
        waited_count = '0;
        released_count = '0;
      end
      default: begin
      end
    endcase
    r.occupancy = held_count;
    r.pending_downstream = released_count;
    return r;
  endfunction

  function automatic cmd_t random_command(input int n);
    cmd_t c;
    int   pick;
    int   acquire_share;
    c.image_id = 8'($urandom);
    pick = $urandom_range(99);
    case ((n / 50) % 3)
      0: acquire_share = 55;
      1: acquire_share = 28;
      default: acquire_share = 15;
    endcase
    if (pick < 2) begin
      c.command = CMD_CLEAR;
    end else if (pick < 4) begin
      c.command = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    end else if (pick < 4 + acquire_share) begin
      c.command = CMD_ACQUIRE;
    end else begin
      case ($urandom_range(2))
        0: c.command = CMD_WAIT;
        1: c.command = CMD_RELEASE;
        default: c.command = CMD_DOWNSTREAM;
      endcase
    end
    return c;
  endfunction

  function automatic void check_result(input res_t got);
    res_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("unexpected result: found=%0d index=%02h occupancy=%0d pending=%0d ovf=%0d",
                 got.found, got.result_index, got.occupancy, got.pending_downstream,
                 got.overflow);
      return;
    end
    want = expected_results[0];
    expected_results.delete(0);
    if (got.found !== want.found || got.result_index !== want.result_index ||
        got.occupancy !== want.occupancy ||
        got.pending_downstream !== want.pending_downstream ||
        got.overflow !== want.overflow) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("result mismatch at %0t: expected found=%0d index=%02h occupancy=%0d",
                 $realtime, want.found, want.result_index, want.occupancy);
        $display("  pending=%0d ovf=%0d, got found=%0d index=%02h occupancy=%0d",
                 want.pending_downstream, want.overflow, got.found, got.result_index,
                 got.occupancy);
        $display("  pending=%0d ovf=%0d", got.pending_downstream, got.overflow);
      end
    end
  endfunction

  task automatic offer(input cmd_t item, input logic typed, input res_t want);
    res_t predicted;
    while (!calm && $urandom_range(99) < 30) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= item;
    do @(posedge clk); while (cmd_stall);
    predicted = advance_queue(item);
    expected_results.insert(expected_results.size(), typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (res_valid && !res_stall)
        check_result(res);
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // The receiver normally stalls at random; once asked, it holds off for a long
  // stretch so that the block backs up and stalls the sender.
  initial begin
    int held_off;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        res_stall <= 1'b1;
        for (held_off = 0; held_off < SQUEEZE_CYCLES; held_off++)
          @(posedge clk);
      end else begin
        res_stall <= !calm && ($urandom_range(99) < 30);
      end
    end
  end

  initial begin
    int   counted;
    int   n;
    cmd_t item;
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd <= '0;
    calm = 1'b0;
    squeeze_req = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    head_slot = '0;
    held_count = '0;
    waited_count = '0;
    released_count = '0;
    directed_steps = '{
      '{'{CMD_WAIT,        8'h00}, 1'b1, '0},
      '{'{CMD_RELEASE,     8'h00}, 1'b1, '0},
      '{'{CMD_DOWNSTREAM,  8'h00}, 1'b1, '0},
      '{'{CMD_SPARE_FIRST, 8'hFF}, 1'b1, '0},
      '{'{CMD_SPARE_LAST,  8'h00}, 1'b1, '0},
      '{'{CMD_ACQUIRE,     8'h00}, 1'b1, '{1'b0, 8'h00, 4'd1, 4'd0, 1'b0}},
      '{'{CMD_ACQUIRE,     8'hFF}, 1'b1, '{1'b0, 8'h00, 4'd2, 4'd0, 1'b0}},
      '{'{CMD_ACQUIRE,     8'h5A}, 1'b0, '0},
      '{'{CMD_ACQUIRE,     8'hA5}, 1'b0, '0},
      '{'{CMD_ACQUIRE,     8'h01}, 1'b0, '0},
      '{'{CMD_ACQUIRE,     8'h80}, 1'b0, '0},
      '{'{CMD_ACQUIRE,     8'h7F}, 1'b0, '0},
      '{'{CMD_ACQUIRE,     8'hC3}, 1'b0, '0},
      '{'{CMD_ACQUIRE,     8'h11}, 1'b1, '{1'b0, 8'h00, 4'd8, 4'd0, 1'b1}},
      '{'{CMD_WAIT,        8'h00}, 1'b1, '{1'b1, 8'h00, 4'd8, 4'd0, 1'b0}},
      '{'{CMD_WAIT,        8'h33}, 1'b0, '0},
      '{'{CMD_RELEASE,     8'h00}, 1'b0, '0},
      '{'{CMD_RELEASE,     8'hFF}, 1'b0, '0},
      '{'{CMD_RELEASE,     8'h00}, 1'b0, '0},
      '{'{CMD_DOWNSTREAM,  8'h00}, 1'b0, '0},
      '{'{CMD_ACQUIRE,     8'h22}, 1'b0, '0},
      '{'{CMD_DOWNSTREAM,  8'hFF}, 1'b0, '0},
      '{'{CMD_DOWNSTREAM,  8'h00}, 1'b0, '0},
      '{'{CMD_SPARE_LAST,  8'hFF}, 1'b0, '0},
      '{'{CMD_CLEAR,       8'hFF}, 1'b1, '0}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i])
      offer(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].want);

    counted = 0;
    n = 0;
    while (counted < RANDOM_ITEMS) begin
      item = random_command(counted);
      calm = (counted >= 300 && counted < 450);
      if (n == 650)
        squeeze_req = 1'b1;
      n++;
      offer(item, 1'b0, '0);
      if (item.command <= CMD_CLEAR)
        counted++;
    end
    cmd_valid <= 1'b0;

    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
